// ----- src/ltgsu_pkg.sv -----
// shared types, widths and codes of the lpcm two-group sample unpacker
package ltgsu_pkg;

  // widths that cover the whole range of the top-level parameters
  localparam int CH_W       = 4;  // effective channel count, up to 15
  localparam int SIZE_W     = 6;  // block size and byte address, up to 63
  localparam int POS_W      = 6;  // byte position within the block
  localparam int IDX_W      = 4;  // sample index within a block, up to 15
  localparam int CODE_W     = 2;
  localparam int REP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 32;

  // sample width codes
  localparam logic [CODE_W-1:0] WCODE_16 = 2'd0;
  localparam logic [CODE_W-1:0] WCODE_20 = 2'd1;
  localparam logic [CODE_W-1:0] WCODE_24 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_G1_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_G2_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_G1_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_G2_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_G2_REPEAT   = 3'd4;

  // largest group-one blocks per group-two block
  localparam logic [REP_W-1:0] MAX_REPEAT = 3'd4;

  // block geometry derived from the configuration
  typedef struct packed {
    logic [CH_W-1:0]   ch1;
    logic [CH_W-1:0]   ch2;
    logic [CODE_W-1:0] g1_code;
    logic [CODE_W-1:0] g2_code;
    logic [SIZE_W-1:0] g1_size;
    logic [SIZE_W-1:0] g2_size;
    logic [REP_W-1:0]  factor;
  } geom_t;

  // width code three behaves as 24 bits
  function automatic logic [CODE_W-1:0] eff_code(input logic [CODE_W-1:0] code);
    return (code > WCODE_24) ? WCODE_24 : code;
  endfunction

endpackage

// ----- src/ltgsu_in_if.sv -----
// byte input channel of the lpcm unpacker
interface ltgsu_in_if;
  logic                        valid;
  logic                        ready;
  logic [ltgsu_pkg::BYTE_W-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

// ----- src/ltgsu_out_if.sv -----
// sample result channel of the lpcm unpacker
interface ltgsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [ltgsu_pkg::SAMPLE_W-1:0] sample_value;
  logic [2:0]                    channel_slot;
  logic                          from_group2;
  logic                          time_half;
  logic                          last_of_run;

  modport source (output valid, output sample_value, output channel_slot,
                  output from_group2, output time_half, output last_of_run,
                  input ready);
  modport sink   (input valid, input sample_value, input channel_slot,
                  input from_group2, input time_half, input last_of_run,
                  output ready);
endinterface

// ----- src/ltgsu_geom.sv -----
// effective channel counts, block sizes and repeat ratio from the config registers
module ltgsu_geom #(
  parameter int MAX_CHANNELS    = 6,
  parameter int MAX_BLOCK_BYTES = 36
) (
  input  logic [ltgsu_pkg::CFG_DATA_W-1:0] g1_channels,
  input  logic [ltgsu_pkg::CFG_DATA_W-1:0] g2_channels,
  input  logic [ltgsu_pkg::CODE_W-1:0]     g1_width,
  input  logic [ltgsu_pkg::CODE_W-1:0]     g2_width,
  input  logic [ltgsu_pkg::REP_W-1:0]      g2_repeat,
  output ltgsu_pkg::geom_t                 geom
);

  localparam int CH_W   = ltgsu_pkg::CH_W;
  localparam int SIZE_W = ltgsu_pkg::SIZE_W;

  // channels that fit in one block at each width
  localparam int FIT16 = MAX_BLOCK_BYTES / 4;
  localparam int FIT20 = MAX_BLOCK_BYTES / 5;
  localparam int FIT24 = MAX_BLOCK_BYTES / 6;
  localparam logic [CH_W-1:0] MAXCH = CH_W'(MAX_CHANNELS);

  logic [ltgsu_pkg::CODE_W-1:0] code1, code2;
  logic [CH_W-1:0]              fit1, fit2, c1, c2, room;
  logic [SIZE_W-1:0]            bpc1, bpc2;

  // fit and bytes per channel for each group
  always_comb begin
    code1 = ltgsu_pkg::eff_code(g1_width);
    code2 = ltgsu_pkg::eff_code(g2_width);
    unique case (code1)
      ltgsu_pkg::WCODE_16: fit1 = CH_W'(FIT16);
      ltgsu_pkg::WCODE_20: fit1 = CH_W'(FIT20);
      default:             fit1 = CH_W'(FIT24);
    endcase
    unique case (code2)
      ltgsu_pkg::WCODE_16: fit2 = CH_W'(FIT16);
      ltgsu_pkg::WCODE_20: fit2 = CH_W'(FIT20);
      default:             fit2 = CH_W'(FIT24);
    endcase
    bpc1 = SIZE_W'(4) + SIZE_W'(code1);
    bpc2 = SIZE_W'(4) + SIZE_W'(code2);
  end

  // channel count saturation
  always_comb begin
    c1 = CH_W'(g1_channels);
    if (c1 == '0) c1 = CH_W'(1);
    if (c1 > MAXCH) c1 = MAXCH;
    if (c1 > fit1) c1 = fit1;
    room = MAXCH - c1;
    c2 = CH_W'(g2_channels);
    if (c2 > room) c2 = room;
    if (c2 > fit2) c2 = fit2;
  end

  // geometry record
  always_comb begin
    geom.ch1     = c1;
    geom.ch2     = c2;
    geom.g1_code = code1;
    geom.g2_code = code2;
    geom.g1_size = SIZE_W'(c1) * bpc1;
    geom.g2_size = SIZE_W'(c2) * bpc2;
    if (c2 == '0 || g2_repeat == '0) begin
      geom.factor = ltgsu_pkg::REP_W'(1);
    end else if (g2_repeat > ltgsu_pkg::MAX_REPEAT) begin
      geom.factor = ltgsu_pkg::MAX_REPEAT;
    end else begin
      geom.factor = g2_repeat;
    end
  end

endmodule

// ----- src/ltgsu_sample_asm.sv -----
// shared sample assembler: word bytes plus extension into a left-justified 32-bit value
module ltgsu_sample_asm (
  input  logic [ltgsu_pkg::BYTE_W-1:0]   hi_byte,
  input  logic [ltgsu_pkg::BYTE_W-1:0]   lo_byte,
  input  logic [ltgsu_pkg::BYTE_W-1:0]   ext_byte,
  input  logic [ltgsu_pkg::CODE_W-1:0]   code,
  input  logic                           odd,
  output logic [ltgsu_pkg::SAMPLE_W-1:0] value
);

  logic [ltgsu_pkg::BYTE_W-1:0] ext;

  // 20-bit: even sample takes the high nibble, odd the low nibble, both in bits 7..4
  always_comb begin
    unique case (code)
      ltgsu_pkg::WCODE_20: ext = odd ? {ext_byte[3:0], 4'h0} : {ext_byte[7:4], 4'h0};
      ltgsu_pkg::WCODE_24: ext = ext_byte;
      default:             ext = '0;
    endcase
    value = {hi_byte, lo_byte, ext, 8'h00};
  end

endmodule

// ----- src/lpcm_two_group_sample_unpacker_unit.sv -----
// top level of the lpcm two-group sample unpacker: byte buffer, sequencer and output register
//
// in_ch takes one raw payload byte per transfer; out_ch gives one sample per transfer
// with its channel slot, group, time half and a last flag on the final sample of a block.
// cfg_we/cfg_index/cfg_data write the five configuration registers; the user must do this
// only while idle, as the block does not enforce it. A byte that does not finish a block
// goes through transfer and block check; the byte that finishes a group-two block starts a
// load pass, one that finishes a group-one block an output pass. Each sample read from the
// buffer goes through S_RD_HI, S_RD_LO, S_RD_EXT and S_FINISH; stored group-two samples
// leave from S_G2_OUT. The first result is registered in S_FINISH after S_CHECK and the
// read states, as the byte buffer has a single read port: each group-one sample needs three
// byte reads through the one shared sample assembler. in_ch.ready is low during a pass.
// When the receiver stalls, the output register holds its sample and the pass waits;
// the last sample of a pass may still wait while the next bytes are taken.
// Synchronous reset restores the default configuration, clears the position,
// repeat count and group-two store and drops out_ch.valid. There is no clearing pass.
module lpcm_two_group_sample_unpacker_unit #(
  parameter int MAX_CHANNELS    = 6,
  parameter int MAX_BLOCK_BYTES = 36
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ltgsu_in_if.sink                           in_ch,
  ltgsu_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [ltgsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ltgsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CH_W     = ltgsu_pkg::CH_W;
  localparam int SIZE_W   = ltgsu_pkg::SIZE_W;
  localparam int POS_W    = ltgsu_pkg::POS_W;
  localparam int IDX_W    = ltgsu_pkg::IDX_W;
  localparam int CODE_W   = ltgsu_pkg::CODE_W;
  localparam int REP_W    = ltgsu_pkg::REP_W;
  localparam int BYTE_W   = ltgsu_pkg::BYTE_W;
  localparam int SAMPLE_W = ltgsu_pkg::SAMPLE_W;
  localparam int MEM_AW   = $clog2(MAX_BLOCK_BYTES);
  localparam int G2_DEPTH = 2 * (MAX_CHANNELS - 1);
  localparam int G2_AW    = (G2_DEPTH > 1) ? $clog2(G2_DEPTH) : 1;
  localparam logic [POS_W-1:0] MEM_DEPTH = POS_W'(MAX_BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD_HI, S_RD_LO, S_RD_EXT, S_FINISH, S_G2_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEG_G1_T0, SEG_G2_T0, SEG_G1_T1, SEG_G2_T1
  } seg_t;

  // configuration registers
  logic [ltgsu_pkg::CFG_DATA_W-1:0] g1_channels_r, g2_channels_r, g2_repeat_r;
  logic [CODE_W-1:0]                g1_width_r, g2_width_r;

  // sequencer and block state
  state_t             state_r;
  seg_t               seg_r;
  logic               loading_r;
  logic [IDX_W-1:0]   idx_r;
  logic [POS_W-1:0]   pos_r;
  logic [1:0]         rep_r;
  logic               loaded_r;
  logic [BYTE_W-1:0]  hi_r, lo_r, rdata_r;
  logic [SAMPLE_W-1:0] store_r [G2_DEPTH];
  logic [BYTE_W-1:0]  mem [MAX_BLOCK_BYTES];

  // output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic [2:0]          out_slot_r;
  logic                out_g2_r, out_half_r, out_last_r;

  ltgsu_pkg::geom_t    geom;
  logic                in_xfer, mem_we, slot_free, g2_pending;
  logic [CH_W-1:0]     samp_ch, seg_cnt;
  logic [CODE_W-1:0]   samp_code;
  logic [IDX_W-1:0]    samp_idx, st_idx, adv_idx;
  logic [SIZE_W-1:0]   addr_hi, addr_lo, addr_ext, rd_addr;
  logic [SAMPLE_W-1:0] asm_value, emit_raw, emit_value;
  seg_t                adv_seg;
  logic                adv_done;
  logic [REP_W-1:0]    rep_inc;
  logic [1:0]          rep_nxt;

  ltgsu_geom #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_geom (
    .g1_channels (g1_channels_r),
    .g2_channels (g2_channels_r),
    .g1_width    (g1_width_r),
    .g2_width    (g2_width_r),
    .g2_repeat   (g2_repeat_r),
    .geom        (geom)
  );

  ltgsu_sample_asm u_asm (
    .hi_byte  (hi_r),
    .lo_byte  (lo_r),
    .ext_byte (rdata_r),
    .code     (samp_code),
    .odd      (samp_idx[0]),
    .value    (asm_value)
  );

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && (state_r == S_IDLE);
  assign mem_we      = in_xfer && (pos_r < MEM_DEPTH);
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_value_r;
  assign out_ch.channel_slot = out_slot_r;
  assign out_ch.from_group2  = out_g2_r;
  assign out_ch.time_half    = out_half_r;
  assign out_ch.last_of_run  = out_last_r;

  // sample being worked on and its byte addresses
  always_comb begin
    samp_ch   = loading_r ? geom.ch2 : geom.ch1;
    samp_code = loading_r ? geom.g2_code : geom.g1_code;
    if (!loading_r && seg_r == SEG_G1_T1) begin
      samp_idx = IDX_W'(geom.ch1) + idx_r;
    end else begin
      samp_idx = idx_r;
    end
    addr_hi  = SIZE_W'({samp_idx, 1'b0});
    addr_lo  = addr_hi | SIZE_W'(1);
    addr_ext = SIZE_W'({samp_ch, 2'b00}) +
               ((samp_code == ltgsu_pkg::WCODE_20) ? SIZE_W'(samp_idx >> 1)
                                                   : SIZE_W'(samp_idx));
    unique case (state_r)
      S_RD_LO:            rd_addr = addr_lo;
      S_RD_EXT, S_FINISH: rd_addr = (samp_code == ltgsu_pkg::WCODE_16) ? addr_hi : addr_ext;
      default:            rd_addr = addr_hi;
    endcase
  end

  // byte buffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r[MEM_AW-1:0]] <= in_ch.raw_byte;
    end
    rdata_r <= mem[rd_addr[MEM_AW-1:0]];
  end

  // output order walk: group-one t0, group-two t0, group-one t1, group-two t1
  always_comb begin
    seg_cnt  = (seg_r == SEG_G1_T0 || seg_r == SEG_G1_T1) ? geom.ch1 : geom.ch2;
    adv_seg  = seg_r;
    adv_idx  = idx_r + IDX_W'(1);
    adv_done = 1'b0;
    if (idx_r == IDX_W'(seg_cnt) - IDX_W'(1)) begin
      adv_idx = '0;
      unique case (seg_r)
        SEG_G1_T0: adv_seg = (geom.ch2 != '0) ? SEG_G2_T0 : SEG_G1_T1;
        SEG_G2_T0: adv_seg = SEG_G1_T1;
        SEG_G1_T1: begin
          if (geom.ch2 != '0) adv_seg = SEG_G2_T1;
          else adv_done = 1'b1;
        end
        default:   adv_done = 1'b1;
      endcase
    end
  end

  // result value, 16-bit mode keeps the top half in the low bits
  always_comb begin
    st_idx     = (seg_r == SEG_G2_T1) ? IDX_W'(geom.ch2) + idx_r : idx_r;
    emit_raw   = (state_r == S_G2_OUT) ? store_r[st_idx[G2_AW-1:0]] : asm_value;
    emit_value = (geom.g1_code == ltgsu_pkg::WCODE_16) ?
                 {16'h0000, emit_raw[SAMPLE_W-1:16]} : emit_raw;
  end

  // block bookkeeping
  always_comb begin
    g2_pending = (rep_r == '0) && !loaded_r && (geom.g2_size != '0);
    rep_inc    = REP_W'(rep_r) + REP_W'(1);
    rep_nxt    = (rep_inc >= geom.factor) ? 2'd0 : rep_inc[1:0];
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seg_r         <= SEG_G1_T0;
      loading_r     <= 1'b0;
      idx_r         <= '0;
      pos_r         <= '0;
      rep_r         <= '0;
      loaded_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      g1_channels_r <= 3'd2;
      g2_channels_r <= 3'd0;
      g1_width_r    <= ltgsu_pkg::WCODE_16;
      g2_width_r    <= ltgsu_pkg::WCODE_16;
      g2_repeat_r   <= 3'd1;
      for (int i = 0; i < G2_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          ltgsu_pkg::CFG_G1_CHANNELS: g1_channels_r <= cfg_data;
          ltgsu_pkg::CFG_G2_CHANNELS: g2_channels_r <= cfg_data;
          ltgsu_pkg::CFG_G1_WIDTH:    g1_width_r    <= cfg_data[CODE_W-1:0];
          ltgsu_pkg::CFG_G2_WIDTH:    g2_width_r    <= cfg_data[CODE_W-1:0];
          ltgsu_pkg::CFG_G2_REPEAT:   g2_repeat_r   <= cfg_data;
          default: ;
        endcase
      end

      // output transfer frees the register unless a new sample takes it
      if (out_valid_r && out_ch.ready &&
          !(state_r == S_G2_OUT || (state_r == S_FINISH && !loading_r))) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (pos_r != '1) pos_r <= pos_r + POS_W'(1);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (g2_pending) begin
            if (SIZE_W'(pos_r) >= geom.g2_size) begin
              loading_r <= 1'b1;
              idx_r     <= '0;
              state_r   <= S_RD_HI;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (SIZE_W'(pos_r) >= geom.g1_size) begin
            loading_r <= 1'b0;
            seg_r     <= SEG_G1_T0;
            idx_r     <= '0;
            state_r   <= S_RD_HI;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RD_HI: state_r <= S_RD_LO;
        S_RD_LO: begin
          hi_r    <= rdata_r;
          state_r <= S_RD_EXT;
        end
        S_RD_EXT: begin
          lo_r    <= rdata_r;
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (loading_r) begin
            // group-two load pass
            store_r[idx_r[G2_AW-1:0]] <= asm_value;
            if (idx_r == IDX_W'({geom.ch2, 1'b0}) - IDX_W'(1)) begin
              loaded_r <= 1'b1;
              pos_r    <= '0;
              state_r  <= S_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_RD_HI;
            end
          end else if (slot_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= emit_value;
            out_slot_r  <= idx_r[2:0];
            out_g2_r    <= 1'b0;
            out_half_r  <= (seg_r == SEG_G1_T1);
            out_last_r  <= adv_done;
            seg_r       <= adv_seg;
            idx_r       <= adv_idx;
            if (adv_done) begin
              rep_r    <= rep_nxt;
              loaded_r <= 1'b0;
              pos_r    <= '0;
              state_r  <= S_IDLE;
            end else begin
              state_r <= (adv_seg == SEG_G1_T0 || adv_seg == SEG_G1_T1) ? S_RD_HI
                                                                        : S_G2_OUT;
            end
          end
        end
        S_G2_OUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= emit_value;
            out_slot_r  <= idx_r[2:0];
            out_g2_r    <= 1'b1;
            out_half_r  <= (seg_r == SEG_G2_T1);
            out_last_r  <= adv_done;
            seg_r       <= adv_seg;
            idx_r       <= adv_idx;
            if (adv_done) begin
              rep_r    <= rep_nxt;
              loaded_r <= 1'b0;
              pos_r    <= '0;
              state_r  <= S_IDLE;
            end else begin
              state_r <= (adv_seg == SEG_G1_T1) ? S_RD_HI : S_G2_OUT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench for the lpcm two-group sample unpacker: byte stream in, predicted samples checked out
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD   = 5;
  localparam int MAX_CH        = 6;
  localparam int BLOCK_BYTES   = 36;
  localparam int G2_DEPTH      = 2 * (MAX_CH - 1);
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 120;
  localparam int IDLE_PCT      = 26;

  // width code three has no name in the package, it acts as 24 bits
  localparam logic [ltgsu_pkg::CODE_W-1:0]    WCODE_SPARE      = 2'd3;
  localparam logic [ltgsu_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_CFG =
    ltgsu_pkg::CFG_G2_REPEAT + 3'd1;

  typedef struct packed {
    logic [ltgsu_pkg::SAMPLE_W-1:0] value;
    logic [2:0]                     slot;
    logic                           group2;
    logic                           half;
    logic                           last;
  } sample_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [ltgsu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ltgsu_pkg::CFG_DATA_W-1:0] cfg_data;

  ltgsu_in_if  in_ch ();
  ltgsu_out_if out_ch ();

  lpcm_two_group_sample_unpacker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // configuration mirror, reset values
  logic [2:0]                   g1_channels = 3'd2;
  logic [2:0]                   g2_channels = 3'd0;
  logic [ltgsu_pkg::CODE_W-1:0] g1_code     = ltgsu_pkg::WCODE_16;
  logic [ltgsu_pkg::CODE_W-1:0] g2_code     = ltgsu_pkg::WCODE_16;
  logic [2:0]                   g2_repeat   = 3'd1;

  // unpacker state mirror
  logic [7:0]                     byte_buf [BLOCK_BYTES];
  logic [ltgsu_pkg::SAMPLE_W-1:0] g2_samples [G2_DEPTH];
  int                             byte_pos  = 0;
  int                             rep_count = 0;
  logic                           g2_loaded = 1'b0;

  sample_t expected_samples [$];
  int      error_count   = 0;
  int      bytes_sent    = 0;
  int      in_idle_pct   = IDLE_PCT;
  int      out_idle_pct  = IDLE_PCT;
  int      hold_off_left = 0;

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #5_000_000;
    $display("[lpcm_two_group_sample_unpacker_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int bytes_per_channel(input logic [ltgsu_pkg::CODE_W-1:0] code);
    return (code == ltgsu_pkg::WCODE_20) ? 5 : ((code == ltgsu_pkg::WCODE_16) ? 4 : 6);
  endfunction

  function automatic logic [7:0] buf_byte(input int idx);
    return (idx < BLOCK_BYTES) ? byte_buf[idx] : 8'h00;
  endfunction

  // left-justified sample: hi, lo, extension bits, zero byte
  function automatic logic [ltgsu_pkg::SAMPLE_W-1:0] assemble_sample(
    input int i, input int ch, input logic [ltgsu_pkg::CODE_W-1:0] code);
    logic [7:0] ext;
    logic [7:0] nib;
    ext = 8'h00;
    if (code == ltgsu_pkg::WCODE_20) begin
      nib = buf_byte(4 * ch + i / 2);
      ext = (i % 2 == 1) ? {nib[3:0], 4'h0} : {nib[7:4], 4'h0};
    end else if (code != ltgsu_pkg::WCODE_16) begin
      ext = buf_byte(4 * ch + i);
    end
    return {buf_byte(2 * i), buf_byte(2 * i + 1), ext, 8'h00};
  endfunction

  task automatic queue_sample(input logic [ltgsu_pkg::SAMPLE_W-1:0] v, input int slot,
                              input logic grp, input logic half, input logic last);
    sample_t s;
    s.value  = (g1_code == ltgsu_pkg::WCODE_16) ? (v >> 16) : v;
    s.slot   = slot[2:0];
    s.group2 = grp;
    s.half   = half;
    s.last   = last;
    expected_samples.push_back(s);
  endtask

  // advance the mirror by one accepted byte and queue the samples it releases
  task automatic unpack_byte(input logic [7:0] b);
    int ch1, ch2, fit, g1_size, g2_size, ratio, n, k, i, half;
    ch1 = (g1_channels == 3'd0) ? 1 : int'(g1_channels);
    if (ch1 > MAX_CH) ch1 = MAX_CH;
    fit = BLOCK_BYTES / bytes_per_channel(g1_code);
    if (ch1 > fit) ch1 = fit;
    ch2 = int'(g2_channels);
    if (ch2 > MAX_CH - ch1) ch2 = MAX_CH - ch1;
    fit = BLOCK_BYTES / bytes_per_channel(g2_code);
    if (ch2 > fit) ch2 = fit;
    g1_size = ch1 * bytes_per_channel(g1_code);
    g2_size = ch2 * bytes_per_channel(g2_code);

    if (byte_pos < BLOCK_BYTES) byte_buf[byte_pos] = b;
    if (byte_pos < 63) byte_pos++;

    // group-two block comes first in each repeat sequence
    if (rep_count == 0 && !g2_loaded && g2_size > 0) begin
      if (byte_pos >= g2_size) begin
        for (i = 0; i < 2 * ch2 && i < G2_DEPTH; i++)
          g2_samples[i] = assemble_sample(i, ch2, g2_code);
        g2_loaded = 1'b1;
        byte_pos  = 0;
      end
      return;
    end
    if (byte_pos < g1_size) return;

    // group 1 then group 2, first time half then second
    n = 2 * (ch1 + ch2);
    k = 0;
    for (half = 0; half < 2; half++) begin
      for (i = 0; i < ch1; i++) begin
        queue_sample(assemble_sample(half * ch1 + i, ch1, g1_code), i, 1'b0, half[0], k == n - 1);
        k++;
      end
      for (i = 0; i < ch2; i++) begin
        queue_sample(g2_samples[half * ch2 + i], i, 1'b1, half[0], k == n - 1);
        k++;
      end
    end

    ratio = int'(g2_repeat);
    if (ch2 == 0 || ratio == 0) ratio = 1;
    if (ratio > 4) ratio = 4;
    rep_count = (rep_count + 1 >= ratio) ? 0 : ((rep_count + 1) & 3);
    g2_loaded = 1'b0;
    byte_pos  = 0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
    error_count++;
  endtask

  // compare each output transfer with the oldest expected sample
  always @(posedge clk) begin
    sample_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report("unexpected sample", out_ch.sample_value, 32'h0);
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample_value !== want.value)
          report("sample_value", out_ch.sample_value, want.value);
        if (out_ch.channel_slot !== want.slot)
          report("channel_slot", 32'(out_ch.channel_slot), 32'(want.slot));
        if (out_ch.from_group2 !== want.group2)
          report("from_group2", 32'(out_ch.from_group2), 32'(want.group2));
        if (out_ch.time_half !== want.half)
          report("time_half", 32'(out_ch.time_half), 32'(want.half));
        if (out_ch.last_of_run !== want.last)
          report("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.raw_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    unpack_byte(b);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_bytes(input int n);
    repeat (n) send_byte(random_byte());
  endtask

  // keep feeding until the group-two repeat sequence is back at its start
  task automatic complete_group_cycle();
    while (byte_pos != 0 || rep_count != 0 || g2_loaded) send_byte(random_byte());
  endtask

  // input paused until every expected sample is out and the block is quiet
  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [ltgsu_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ltgsu_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ltgsu_pkg::CFG_G1_CHANNELS: g1_channels = val;
      ltgsu_pkg::CFG_G2_CHANNELS: g2_channels = val;
      ltgsu_pkg::CFG_G1_WIDTH:    g1_code     = val[ltgsu_pkg::CODE_W-1:0];
      ltgsu_pkg::CFG_G2_WIDTH:    g2_code     = val[ltgsu_pkg::CODE_W-1:0];
      ltgsu_pkg::CFG_G2_REPEAT:   g2_repeat   = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [2:0] ch1, input logic [2:0] ch2,
                              input logic [ltgsu_pkg::CODE_W-1:0] c1,
                              input logic [ltgsu_pkg::CODE_W-1:0] c2,
                              input logic [2:0] rep);
    wait_results_done();
    write_register(ltgsu_pkg::CFG_G1_CHANNELS, ch1);
    write_register(ltgsu_pkg::CFG_G2_CHANNELS, ch2);
    write_register(ltgsu_pkg::CFG_G1_WIDTH, {1'b0, c1});
    write_register(ltgsu_pkg::CFG_G2_WIDTH, {1'b0, c2});
    write_register(ltgsu_pkg::CFG_G2_REPEAT, rep);
  endtask

  // ---------------------------------------------------------------- tests

  // reset configuration: two 16-bit channels, extreme sample words
  task automatic test_reset_defaults();
    send_byte(8'hff); send_byte(8'hff); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h80); send_byte(8'h00); send_byte(8'h7f); send_byte(8'hff);
  endtask

  // zero channels, spare width code, 20-bit nibbles in both groups, repeat zero
  task automatic test_directed_corners();
    set_geometry(3'd0, 3'd0, WCODE_SPARE, ltgsu_pkg::WCODE_16, 3'd1);
    send_byte(8'h01); send_byte(8'h23); send_byte(8'hfe);
    send_byte(8'hdc); send_byte(8'ha5); send_byte(8'h5a);
    set_geometry(3'd1, 3'd1, ltgsu_pkg::WCODE_20, ltgsu_pkg::WCODE_20, 3'd0);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78); send_byte(8'h9c);
    send_byte(8'hff); send_byte(8'h00); send_byte(8'h00); send_byte(8'hff); send_byte(8'he1);
  endtask

  // listed extremes first, then random settings biased to small blocks
  task automatic test_random_phases();
    int start, phase;
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      case (phase)
        0: set_geometry(3'd6, 3'd0, ltgsu_pkg::WCODE_24, ltgsu_pkg::WCODE_24, 3'd1);
        1: set_geometry(3'd7, 3'd3, ltgsu_pkg::WCODE_20, ltgsu_pkg::WCODE_16, 3'd5);
        2: set_geometry(3'd1, 3'd5, ltgsu_pkg::WCODE_16, ltgsu_pkg::WCODE_24, 3'd4);
        3: set_geometry(3'd1, 3'd7, ltgsu_pkg::WCODE_16, ltgsu_pkg::WCODE_20, 3'd7);
        4: set_geometry(3'd2, 3'd3, ltgsu_pkg::WCODE_24, WCODE_SPARE, 3'd2);
        5: set_geometry(3'd3, 3'd2, ltgsu_pkg::WCODE_20, ltgsu_pkg::WCODE_20, 3'd3);
        6: set_geometry(3'd0, 3'd1, ltgsu_pkg::WCODE_16, ltgsu_pkg::WCODE_16, 3'd0);
        default: begin
          set_geometry(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2)),
                       ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2)),
                       2'($urandom_range(3)), 2'($urandom_range(3)), 3'($urandom_range(7)));
        end
      endcase
      // writes to indexes past the last register must change nothing
      if (phase == 3) write_register(FIRST_UNUSED_CFG + 3'($urandom_range(2)), 3'd7);
      send_random_bytes($urandom_range(6, 24));
      complete_group_cycle();
      phase++;
    end
  endtask

  // settings changed while a block is partly gathered
  task automatic test_config_mid_block();
    set_geometry(3'd2, 3'd0, ltgsu_pkg::WCODE_16, ltgsu_pkg::WCODE_16, 3'd1);
    send_random_bytes(5);
    wait_results_done();
    // enough bytes already held: the next byte completes the block
    write_register(ltgsu_pkg::CFG_G1_CHANNELS, 3'd1);
    send_random_bytes(4);
    wait_results_done();
    // group two appears while bytes are held
    write_register(ltgsu_pkg::CFG_G2_CHANNELS, 3'd1);
    write_register(ltgsu_pkg::CFG_G2_REPEAT, 3'd3);
    send_random_bytes(9);
    wait_results_done();
    // repeat count now beyond the new ratio
    write_register(ltgsu_pkg::CFG_G2_REPEAT, 3'd2);
    send_random_bytes(4);
    complete_group_cycle();
  endtask

  // long receiver hold-off with the sender pushing, then a full pause mid-stream
  task automatic test_backpressure();
    set_geometry(3'd1, 3'd2, ltgsu_pkg::WCODE_16, ltgsu_pkg::WCODE_16, 3'd2);
    in_idle_pct = 0;
    send_random_bytes(2);
    hold_off_left = 300;
    send_random_bytes(16);
    in_idle_pct = IDLE_PCT;
    wait_results_done();
    send_random_bytes(20);
    complete_group_cycle();
  endtask

  // both sides always ready
  task automatic test_steady_stream();
    set_geometry(3'd2, 3'd2, ltgsu_pkg::WCODE_20, ltgsu_pkg::WCODE_24, 3'd2);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random_bytes(30);
    complete_group_cycle();
    wait_results_done();
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  task automatic finish_run();
    wait_results_done();
    if (error_count == 0) begin
      $display("[lpcm_two_group_sample_unpacker_unit] OK");
    end else begin
      $display("[lpcm_two_group_sample_unpacker_unit] ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ltgsu_pkg::CFG_G1_CHANNELS;
    cfg_data       = 3'd0;
    in_ch.valid    = 1'b0;
    in_ch.raw_byte = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_corners();
    test_random_phases();
    test_config_mid_block();
    test_backpressure();
    test_steady_stream();
    finish_run();
  end

endmodule
